// ===== sv/lbci_pkg.sv =====
// Package for the lattice-ladder biquad cascade.
// Holds shared constants and fixed-point helpers; no dependencies.
package lbci_pkg;

  localparam int MAX_SECTIONS_DEF = 8;
  // The blend divides by CHUNK_DEF with a shift, so it must stay a power of two.
  localparam int CHUNK_DEF        = 64;
  localparam int NCOEF_PER_SEC    = 5;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_COMMIT = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] SEL_K0 = 3'd0;
  localparam logic [2:0] SEL_K1 = 3'd1;
  localparam logic [2:0] SEL_V0 = 3'd2;
  localparam logic [2:0] SEL_V1 = 3'd3;
  localparam logic [2:0] SEL_V2 = 3'd4;

  localparam logic [3:0] SECTIONS_RESET = 4'd2;

  localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] S40_MIN = -40'sh80_0000_0000;

  // Saturate a wide sum to 40 bits.
  function automatic logic signed [39:0] sat40(input logic signed [45:0] x);
    logic signed [39:0] r;
    if (x > 46'(S40_MAX)) r = S40_MAX;
    else if (x < 46'(S40_MIN)) r = S40_MIN;
    else r = x[39:0];
    return r;
  endfunction

  // Saturate a 40-bit value to a 24-bit sample.
  function automatic logic signed [23:0] sat24(input logic signed [39:0] x);
    logic signed [23:0] r;
    if (x > 40'sd8388607) r = 24'sh7FFFFF;
    else if (x < -40'sd8388608) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction

endpackage

// ===== sv/lattice_biquad_cascade_interp.sv =====
// Top level of the lattice-ladder biquad cascade with coefficient cross-fade.
// Uses lbci_pkg and lbci_mac.
//
// Channels: in_* carries one transaction per item (func selects sample,
// pending coefficient write or commit); out_sample_out returns one result
// per sample transaction; cfg_data writes sections_in_use.
// Sections are walked serially. Per section a sequencer fetches five
// coefficients (and their previous values while blending) from the coefficient
// memory, blends them, and runs seven multiplies through one multiplier, each
// as a MUL state followed by a MULW state. A commit copies the pending table
// into the active table (and active into previous when keep_state is set), one
// entry per cycle; without keep_state it then clears the section state. After
// reset a clearing pass zeroes all memories; no input transaction is taken
// meanwhile. The output register holds a result until taken; the next item is
// accepted meanwhile, but a new sample cannot finish until the previous
// result has left.
module lattice_biquad_cascade_interp
  import lbci_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [23:0] in_sample_in,
  input  logic [2:0]         in_section,
  input  logic [2:0]         in_coef_select,
  input  logic signed [31:0] in_coef_value,
  input  logic               in_keep_state,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_sample_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  localparam int CHUNK = CHUNK_DEF;
  localparam int NC  = MAX_SECTIONS * NCOEF_PER_SEC;
  localparam int AW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int NS  = MAX_SECTIONS * 2;
  localparam int SW  = (NS > 1) ? $clog2(NS) : 1;
  localparam int JW  = $clog2(MAX_SECTIONS + 1);
  localparam int BW  = $clog2(CHUNK + 1);
  localparam int CW  = $clog2(CHUNK);
  localparam logic [AW:0] NC_L = (AW + 1)'(NC);
  localparam logic [SW:0] NS_L = (SW + 1)'(NS);

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b000000000001,
    ST_IDLE   = 12'b000000000010,
    ST_COPY   = 12'b000000000100,
    ST_ZERO   = 12'b000000001000,
    ST_SEC    = 12'b000000010000,
    ST_FETCH  = 12'b000000100000,
    ST_BLEND  = 12'b000001000000,
    ST_MUL    = 12'b000010000000,
    ST_MULW   = 12'b000100000000,
    ST_STORE  = 12'b001000000000,
    ST_OUT    = 12'b010000000000,
    ST_WAIT   = 12'b100000000000
  } state_t;

  // Coefficient memories: pending, active, previous.
  logic signed [31:0] pend_mem [NC];
  logic signed [31:0] act_mem  [NC];
  logic signed [31:0] prev_mem [NC];
  logic signed [39:0] st_mem   [NS];

  state_t             st_r, st_nxt;
  logic [3:0]         used_cfg_r;
  logic [AW:0]        ptr_r;
  logic [BW-1:0]      bcnt_r;
  logic               blending_r;
  logic               keep_r;
  logic [JW-1:0]      sec_r, used_r;
  logic [2:0]         ci_r;
  logic [2:0]         step_r;
  logic signed [31:0] coef_r [NCOEF_PER_SEC];
  logic signed [39:0] x_r, s0_r, s1_r, n0_r, n1_r, t_r, acc_r;
  logic signed [43:0] ks_r;
  logic signed [45:0] a_r;
  logic signed [31:0] act_q_r, prev_q_r, pend_q_r;
  logic signed [39:0] st_q_r;
  logic signed [23:0] out_r;
  logic               out_v_r;
  logic               cp_v_r;
  logic [AW-1:0]      cp_a_r;

  logic signed [31:0] mc;
  logic signed [39:0] mx;
  logic signed [43:0] mp;

  lbci_mac u_mac (.clk(clk), .c(mc), .x(mx), .p(mp));

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_v_r;
  assign out_sample_out = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) used_cfg_r <= SECTIONS_RESET;
    else if (cfg_valid) used_cfg_r <= cfg_data;
  end

  logic [AW-1:0] cidx;
  logic [AW-1:0] ra;
  assign cidx = AW'(32'(sec_r) * NCOEF_PER_SEC + 32'(ci_r));
  // The copy walks the active table through the same read port.
  assign ra   = (st_r == ST_COPY) ? ptr_r[AW-1:0] : cidx;

  // Blend: floor((old*(CHUNK-n) + new*n + CHUNK/2) / CHUNK). CHUNK is a power
  // of two, so the division is an arithmetic shift.
  logic signed [BW+33:0] bsum;
  logic signed [31:0]    bval;
  assign bsum = (BW+34)'(prev_q_r) * $signed({1'b0, (BW)'(CHUNK) - bcnt_r})
              + (BW+34)'(act_q_r) * $signed({1'b0, bcnt_r}) + (BW+34)'(CHUNK / 2);
  assign bval = 32'(bsum >>> CW);

  // Multiply operand selection per step.
  // 0: k0*s1  1: k1*s0  2: k1*n0  3: k0*t  4: v2*n0  5: v1*n1  6: v0*acc
  always_comb begin
    mc = coef_r[SEL_K0];
    mx = s1_r;
    unique case (step_r)
      3'd0: begin mc = coef_r[SEL_K0]; mx = s1_r; end
      3'd1: begin mc = coef_r[SEL_K1]; mx = s0_r; end
      3'd2: begin mc = coef_r[SEL_K1]; mx = n0_r; end
      3'd3: begin mc = coef_r[SEL_K0]; mx = t_r; end
      3'd4: begin mc = coef_r[SEL_V2]; mx = n0_r; end
      3'd5: begin mc = coef_r[SEL_V1]; mx = n1_r; end
      3'd6: begin mc = coef_r[SEL_V0]; mx = acc_r; end
      default: begin mc = coef_r[SEL_V0]; mx = acc_r; end
    endcase
  end

  // Memory accesses.
  always_ff @(posedge clk) begin
    act_q_r  <= act_mem[ra];
    prev_q_r <= prev_mem[cidx];
    pend_q_r <= pend_mem[ptr_r[AW-1:0]];
    st_q_r   <= st_mem[SW'(32'(sec_r) * 2 + 32'(ci_r[0]))];
    if (st_r == ST_CLEAR) begin
      pend_mem[ptr_r[AW-1:0]] <= '0;
      act_mem[ptr_r[AW-1:0]]  <= '0;
      prev_mem[ptr_r[AW-1:0]] <= '0;
      if (ptr_r < (AW + 1)'(NS)) st_mem[SW'(ptr_r)] <= '0;
    end else if (st_r == ST_IDLE && in_valid && in_func == FUNC_WRITE &&
                 32'(in_section) < MAX_SECTIONS && in_coef_select <= SEL_V2) begin
      pend_mem[AW'(32'(in_section) * NCOEF_PER_SEC + 32'(in_coef_select))] <= in_coef_value;
    end else if (st_r == ST_ZERO) begin
      st_mem[SW'(ptr_r)] <= '0;
    end else if (st_r == ST_STORE) begin
      st_mem[SW'(32'(sec_r) * 2)]     <= n0_r;
      st_mem[SW'(32'(sec_r) * 2 + 1)] <= n1_r;
    end
    // Copy pipeline: pending and active reads are registered, so the write uses the pointer held in cp_a_r.
    if (cp_v_r) begin
      if (keep_r) prev_mem[cp_a_r] <= act_q_r;
      act_mem[cp_a_r] <= pend_q_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (ptr_r == NC_L - 1'b1) st_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) begin
        if (in_func == FUNC_COMMIT) st_nxt = ST_COPY;
        else if (in_func == FUNC_SAMPLE) st_nxt = ST_SEC;
      end
      ST_COPY:  if (ptr_r == NC_L) st_nxt = keep_r ? ST_IDLE : ST_ZERO;
      ST_ZERO:  if (ptr_r == (AW + 1)'(NS_L) - 1'b1) st_nxt = ST_IDLE;
      ST_SEC:   st_nxt = (sec_r == used_r) ? ST_OUT : ST_FETCH;
      ST_FETCH: st_nxt = ST_BLEND;
      ST_BLEND: if (ci_r == 3'(NCOEF_PER_SEC - 1)) st_nxt = ST_MUL;
      ST_MUL:   st_nxt = ST_MULW;
      ST_MULW:  if (step_r == 3'd6) st_nxt = ST_STORE; else st_nxt = ST_MUL;
      ST_STORE: st_nxt = ST_SEC;
      ST_OUT:   if (!out_v_r || out_ready) st_nxt = ST_IDLE;
      ST_WAIT:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      ptr_r      <= '0;
      bcnt_r     <= '0;
      blending_r <= 1'b0;
      out_v_r    <= 1'b0;
      cp_v_r     <= 1'b0;
      keep_r     <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cp_v_r <= 1'b0;
      if (out_v_r && out_ready) out_v_r <= 1'b0;
      unique case (st_r)
        ST_CLEAR: ptr_r <= (ptr_r == NC_L - 1'b1) ? '0 : ptr_r + 1'b1;
        ST_IDLE: if (in_valid) begin
          ptr_r  <= '0;
          sec_r  <= '0;
          x_r    <= 40'(in_sample_in);
          used_r <= (32'(used_cfg_r) > MAX_SECTIONS) ? JW'(MAX_SECTIONS) : JW'(used_cfg_r);
          if (in_func == FUNC_COMMIT) keep_r <= in_keep_state;
        end
        ST_COPY: begin
          if (ptr_r != NC_L) begin
            cp_v_r <= 1'b1;
            cp_a_r <= ptr_r[AW-1:0];
          end
          if (ptr_r == NC_L) begin
            ptr_r      <= '0;
            bcnt_r     <= '0;
            blending_r <= keep_r;
          end else ptr_r <= ptr_r + 1'b1;
        end
        ST_ZERO: ptr_r <= (ptr_r == (AW + 1)'(NS_L) - 1'b1) ? '0 : ptr_r + 1'b1;
        ST_SEC: ci_r <= '0;
        ST_FETCH: ci_r <= 3'd1;
        ST_BLEND: begin
          // Address for ci_r-1 was presented last cycle; its data is here.
          coef_r[ci_r - 3'd1] <= blending_r ? bval : act_q_r;
          if (ci_r == 3'd1) s0_r <= st_q_r;
          if (ci_r == 3'd2) s1_r <= st_q_r;
          if (ci_r == 3'(NCOEF_PER_SEC - 1)) ci_r <= 3'(NCOEF_PER_SEC);
          else ci_r <= ci_r + 3'd1;
          step_r <= '0;
        end
        ST_MUL: begin
          if (ci_r == 3'(NCOEF_PER_SEC)) begin
            coef_r[NCOEF_PER_SEC - 1] <= blending_r ? bval : act_q_r;
            ci_r <= '0;
          end
        end
        ST_MULW: begin
          step_r <= step_r + 3'd1;
          unique case (step_r)
            3'd0: begin t_r <= sat40(46'(mp) + 46'(x_r)); ks_r <= mp; end
            3'd1: n0_r <= sat40(46'(x_r) + 46'(ks_r) + 46'(mp));
            3'd2: n1_r <= sat40(46'(s0_r) - 46'(mp));
            3'd3: acc_r <= sat40(46'(s1_r) - 46'(mp));
            3'd4: a_r <= 46'(mp);
            3'd5: a_r <= a_r + 46'(mp);
            3'd6: x_r <= sat40(a_r + 46'(mp));
            default: ;
          endcase
        end
        ST_STORE: sec_r <= sec_r + 1'b1;
        ST_OUT: if (!out_v_r || out_ready) begin
          out_v_r <= 1'b1;
          out_r   <= sat24(x_r);
          if (blending_r) begin
            if (bcnt_r == BW'(CHUNK - 1)) begin
              bcnt_r     <= '0;
              blending_r <= 1'b0;
            end else bcnt_r <= bcnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/lbci_mac.sv =====
// Coefficient-times-state multiplier with round to nearest; the result is
// ready in the cycle after the operands. Uses lbci_pkg. The 32x40 product is
// split into two 32x20 partials.
module lbci_mac
  import lbci_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] c,
  input  logic signed [39:0] x,
  output logic signed [43:0] p
);
  logic signed [51:0] ph_r;
  logic signed [52:0] pl_r;
  logic signed [72:0] full;

  // High partial uses the signed upper 20 bits, low partial the unsigned lower 20.
  always_ff @(posedge clk) begin
    ph_r <= 52'(c * $signed(x[39:20]));
    pl_r <= 53'(c * $signed({1'b0, x[19:0]}));
  end

  assign full = (73'(ph_r) <<< 20) + 73'(pl_r) + 73'(1 <<< 27);
  assign p = full[71:28];
endmodule
